[rtl/core/dnsp_pkg.sv]
// Package for the DNS message field parser: phases, kinds, payload structs.
package dnsp_pkg;

    typedef enum logic [3:0] {
        PH_ID    = 4'd0,
        PH_FLAGS = 4'd1,
        PH_QD    = 4'd2,
        PH_AN    = 4'd3,
        PH_NS    = 4'd4,
        PH_AR    = 4'd5,
        PH_NAME  = 4'd6,
        PH_LABEL = 4'd7,
        PH_PTR   = 4'd8,
        PH_TYPE  = 4'd9,
        PH_CLASS = 4'd10,
        PH_TTL   = 4'd11,
        PH_RDLEN = 4'd12,
        PH_RDATA = 4'd13,
        PH_DONE  = 4'd14
    } phase_t;

    localparam logic [3:0] K_ID = 4'd0;
    localparam logic [3:0] K_FLAGS = 4'd1;
    localparam logic [3:0] K_QD = 4'd2;
    localparam logic [3:0] K_CHAR = 4'd6;
    localparam logic [3:0] K_PTR = 4'd7;
    localparam logic [3:0] K_NEND = 4'd8;
    localparam logic [3:0] K_TYPE = 4'd9;
    localparam logic [3:0] K_CLASS = 4'd10;
    localparam logic [3:0] K_TTL = 4'd11;
    localparam logic [3:0] K_RDLEN = 4'd12;
    localparam logic [3:0] K_RDATA = 4'd13;
    localparam logic [3:0] K_ADDR = 4'd14;
    localparam logic [3:0] K_DONE = 4'd15;

    localparam logic [2:0] SEC_HDR = 3'd0;
    localparam logic [2:0] SEC_QUESTION = 3'd1;
    localparam logic [2:0] SEC_ANSWER = 3'd2;
    localparam logic [2:0] SEC_ADDITIONAL = 3'd4;

    localparam int MAX_RES = 3;
    localparam logic [7:0] DOT_CHAR = 8'd46;
    localparam logic [15:0] TYPE_A = 16'd1;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       start_of_message;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [31:0] field_value;
        logic [2:0]  section;
        logic [15:0] entry_index;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t [MAX_RES-1:0] item;
    } result_set_t;

endpackage

[rtl/core/dnsp_core.sv]
// Parse state and the per-byte result generation.
module dnsp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  dnsp_pkg::in_item_t   in_item,
    output dnsp_pkg::result_set_t res
);

    dnsp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  fbc_reg, fbc_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] cnt_reg [1:4];
    logic [15:0] cnt_next [1:4];
    logic [2:0]  sec_reg, sec_next;
    logic [15:0] ent_reg, ent_next;
    logic [7:0]  lab_reg, lab_next;
    logic        first_reg, first_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [15:0] rrem_reg, rrem_next;
    logic [15:0] rpos_reg, rpos_next;
    logic        resp_reg, resp_next;

    // effective state after an optional restart
    dnsp_pkg::phase_t ph;
    logic [2:0]  fbc;
    logic [31:0] acc;
    logic [15:0] cnt [1:4];
    logic [2:0]  sec;
    logic [15:0] ent;
    logic        first;
    logic        resp;
    logic [15:0] rtype, rrem, rpos;
    logic [7:0]  lab;

    logic [7:0]  b;
    logic [15:0] v;
    logic [12:0] f;
    logic [31:0] acc_sh;
    logic [2:0]  hs;
    logic [15:0] he;
    logic        do_next;
    logic [2:0]  nx_sec;
    logic        nx_found;
    logic        nx_same;
    logic [1:0]  n;
    dnsp_pkg::out_item_t [dnsp_pkg::MAX_RES-1:0] it;

    function automatic dnsp_pkg::out_item_t mk(logic [3:0] k, logic [31:0] val,
                                               logic [2:0] s, logic [15:0] e);
        dnsp_pkg::out_item_t o;
        o.field_kind  = k;
        o.field_value = val;
        o.section     = s;
        o.entry_index = e;
        o.last_of_run = 1'b0;
        return o;
    endfunction

    always_comb begin
        b = in_item.msg_byte;
        if (in_item.start_of_message) begin
            ph = dnsp_pkg::PH_ID; fbc = '0; acc = '0; sec = '0; ent = '0;
            for (int i = 1; i <= 4; i++) cnt[i] = '0;
            first = 1'b1; resp = 1'b0; rtype = '0; rrem = '0; rpos = '0; lab = '0;
        end else begin
            ph = phase_reg; fbc = fbc_reg; acc = acc_reg; sec = sec_reg; ent = ent_reg;
            for (int i = 1; i <= 4; i++) cnt[i] = cnt_reg[i];
            first = first_reg; resp = resp_reg; rtype = rtype_reg; rrem = rrem_reg;
            rpos = rpos_reg; lab = lab_reg;
        end

        phase_next = ph; fbc_next = fbc; acc_next = acc; sec_next = sec; ent_next = ent;
        for (int i = 1; i <= 4; i++) cnt_next[i] = cnt[i];
        first_next = first; resp_next = resp; rtype_next = rtype; rrem_next = rrem;
        rpos_next = rpos; lab_next = lab;

        hs = (ph <= dnsp_pkg::PH_AR) ? dnsp_pkg::SEC_HDR : sec;
        he = (ph <= dnsp_pkg::PH_AR) ? 16'd0 : ent;
        v = {acc[7:0], b};
        acc_sh = {acc[23:0], b};
        f = {acc[7], acc[6:3], 1'b0, acc[1], acc[0], 5'd0};
        if (resp) f = f | {5'd0, acc[2], 2'b0, b[7], b[3:0]};
        do_next = 1'b0;
        n = '0;
        for (int i = 0; i < dnsp_pkg::MAX_RES; i++) it[i] = '0;

        unique case (ph)
            dnsp_pkg::PH_ID, dnsp_pkg::PH_FLAGS, dnsp_pkg::PH_QD, dnsp_pkg::PH_AN,
            dnsp_pkg::PH_NS, dnsp_pkg::PH_AR, dnsp_pkg::PH_TYPE, dnsp_pkg::PH_CLASS,
            dnsp_pkg::PH_RDLEN: begin
                if (fbc == 3'd0) begin
                    acc_next = {24'd0, b};
                    fbc_next = 3'd1;
                    if (ph == dnsp_pkg::PH_FLAGS) resp_next = b[7];
                end else begin
                    fbc_next = '0;
                    n = 2'd1;
                    unique case (ph)
                        dnsp_pkg::PH_ID: begin
                            it[0] = mk(dnsp_pkg::K_ID, {16'd0, v}, hs, he);
                            phase_next = dnsp_pkg::PH_FLAGS;
                        end
                        dnsp_pkg::PH_FLAGS: begin
                            it[0] = mk(dnsp_pkg::K_FLAGS, {19'd0, f}, hs, he);
                            phase_next = dnsp_pkg::PH_QD;
                        end
                        dnsp_pkg::PH_QD, dnsp_pkg::PH_AN, dnsp_pkg::PH_NS,
                        dnsp_pkg::PH_AR: begin
                            it[0] = mk(dnsp_pkg::K_QD + (4'(ph) - 4'(dnsp_pkg::PH_QD)),
                                       {16'd0, v}, hs, he);
                            cnt_next[3'(ph) - 3'd1] = v;
                            if (ph == dnsp_pkg::PH_AR) begin
                                sec_next = '0; ent_next = '0; do_next = 1'b1;
                            end else begin
                                phase_next = dnsp_pkg::phase_t'(ph + 4'd1);
                            end
                        end
                        dnsp_pkg::PH_TYPE: begin
                            it[0] = mk(dnsp_pkg::K_TYPE, {16'd0, v}, hs, he);
                            rtype_next = v;
                            phase_next = dnsp_pkg::PH_CLASS;
                        end
                        dnsp_pkg::PH_CLASS: begin
                            it[0] = mk(dnsp_pkg::K_CLASS, {16'd0, v}, hs, he);
                            if (sec == dnsp_pkg::SEC_QUESTION) do_next = 1'b1;
                            else begin
                                phase_next = dnsp_pkg::PH_TTL;
                                acc_next = '0;
                            end
                        end
                        default: begin
                            it[0] = mk(dnsp_pkg::K_RDLEN, {16'd0, v}, hs, he);
                            rrem_next = v; rpos_next = '0; acc_next = '0;
                            if (v == 16'd0) do_next = 1'b1;
                            else phase_next = dnsp_pkg::PH_RDATA;
                        end
                    endcase
                end
            end
            dnsp_pkg::PH_TTL: begin
                acc_next = acc_sh;
                if (fbc == 3'd3) begin
                    fbc_next = '0;
                    n = 2'd1;
                    it[0] = mk(dnsp_pkg::K_TTL, acc_sh, hs, he);
                    phase_next = dnsp_pkg::PH_RDLEN;
                end else begin
                    fbc_next = fbc + 3'd1;
                end
            end
            dnsp_pkg::PH_NAME: begin
                if (b[7]) begin
                    acc_next = {24'd0, b};
                    phase_next = dnsp_pkg::PH_PTR;
                end else if (b == 8'd0) begin
                    n = 2'd1;
                    it[0] = mk(dnsp_pkg::K_NEND, 32'd0, hs, he);
                    phase_next = dnsp_pkg::PH_TYPE;
                    fbc_next = '0;
                end else begin
                    if (!first) begin
                        n = 2'd1;
                        it[0] = mk(dnsp_pkg::K_CHAR, {24'd0, dnsp_pkg::DOT_CHAR}, hs, he);
                    end
                    first_next = 1'b0;
                    lab_next = b;
                    phase_next = dnsp_pkg::PH_LABEL;
                end
            end
            dnsp_pkg::PH_LABEL: begin
                n = 2'd1;
                it[0] = mk(dnsp_pkg::K_CHAR, {24'd0, b}, hs, he);
                lab_next = lab - 8'd1;
                if (lab == 8'd1) phase_next = dnsp_pkg::PH_NAME;
            end
            dnsp_pkg::PH_PTR: begin
                n = 2'd2;
                it[0] = mk(dnsp_pkg::K_PTR, {18'd0, acc[5:0], b}, hs, he);
                it[1] = mk(dnsp_pkg::K_NEND, 32'd0, hs, he);
                phase_next = dnsp_pkg::PH_TYPE;
                fbc_next = '0;
            end
            dnsp_pkg::PH_RDATA: begin
                n = 2'd1;
                it[0] = mk(dnsp_pkg::K_RDATA, {24'd0, b}, hs, he);
                if (rpos < 16'd4) acc_next = acc_sh;
                if (rpos == 16'd3 && sec == dnsp_pkg::SEC_ANSWER &&
                    rtype == dnsp_pkg::TYPE_A) begin
                    n = 2'd2;
                    it[1] = mk(dnsp_pkg::K_ADDR, acc_sh, hs, he);
                end
                if (rpos != 16'hFFFF) rpos_next = rpos + 16'd1;
                rrem_next = rrem - 16'd1;
                if (rrem == 16'd1) do_next = 1'b1;
            end
            default: ;
        endcase

        // advance to next entry / section, or finish
        nx_same = (sec_next >= 3'd1) && (sec_next <= 3'd4) &&
                  ({1'b0, ent_next} + 17'd1 < {1'b0, cnt_next[sec_next[2:0] == 3'd0 ?
                   3'd1 : sec_next]});
        nx_found = 1'b0;
        nx_sec = sec_next;
        for (int s = 4; s >= 1; s--) begin
            if (3'(s) > sec_next && cnt_next[s] != 16'd0) begin
                nx_found = 1'b1;
                nx_sec = 3'(s);
            end
        end
        if (do_next) begin
            if (nx_same || nx_found) begin
                if (nx_same) ent_next = ent_next + 16'd1;
                else begin
                    sec_next = nx_sec;
                    ent_next = '0;
                end
                phase_next = dnsp_pkg::PH_NAME;
                first_next = 1'b1;
                fbc_next = '0;
                acc_next = '0;
            end else begin
                phase_next = dnsp_pkg::PH_DONE;
                it[n] = mk(dnsp_pkg::K_DONE, 32'd0, dnsp_pkg::SEC_HDR, 16'd0);
                n = n + 2'd1;
            end
        end
        if (n != 2'd0) it[n - 2'd1].last_of_run = 1'b1;
        res.count = n;
        res.item = it;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dnsp_pkg::PH_ID; fbc_reg <= '0; acc_reg <= '0;
            for (int i = 1; i <= 4; i++) cnt_reg[i] <= '0;
            sec_reg <= '0; ent_reg <= '0; lab_reg <= '0; first_reg <= 1'b1;
            rtype_reg <= '0; rrem_reg <= '0; rpos_reg <= '0; resp_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next; fbc_reg <= fbc_next; acc_reg <= acc_next;
            for (int i = 1; i <= 4; i++) cnt_reg[i] <= cnt_next[i];
            sec_reg <= sec_next; ent_reg <= ent_next; lab_reg <= lab_next;
            first_reg <= first_next; rtype_reg <= rtype_next; rrem_reg <= rrem_next;
            rpos_reg <= rpos_next; resp_reg <= resp_next;
        end
    end

    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_reg <= dnsp_pkg::SEC_ADDITIONAL) else $error("section out of range");
    a_hdr_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg <= dnsp_pkg::PH_AR) |-> (sec_reg == dnsp_pkg::SEC_HDR))
        else $error("header phase outside header section");
    a_fbc: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != dnsp_pkg::PH_TTL) |-> (fbc_reg <= 3'd1))
        else $error("byte count too large");

endmodule

[rtl/core/dnsp_out_queue.sv]
// Result queue: holds up to three results of one byte and drains them in order.
module dnsp_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dnsp_pkg::result_set_t res,
    input  logic                  load,
    output logic                  can_load,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dnsp_pkg::out_item_t   m_item
);

    dnsp_pkg::out_item_t [dnsp_pkg::MAX_RES-1:0] buf_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg, rd_next;
    logic       pop;

    assign m_valid = cnt_reg != 2'd0;
    assign m_item = buf_reg[rd_reg];
    assign pop = m_valid && m_ready;
    // accept a new byte once the queue is empty or its last result leaves now
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        cnt_next = cnt_reg;
        rd_next = rd_reg;
        if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            rd_next = rd_reg + 2'd1;
        end
        if (load && res.count != 2'd0) begin
            cnt_next = res.count;
            rd_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.count != 2'd0) buf_reg <= res.item;
    end

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> m_item.last_of_run) else $error("last result unmarked");
    a_nolast: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > 2'd1) |-> !m_item.last_of_run) else $error("early last mark");
    a_over: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> can_load) else $error("load into busy queue");

endmodule

[rtl/core/dns_message_field_parser_unit.sv]
// Top level of the DNS message field parser.
// Latency: a byte's first result is valid the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result
// and m_ready is high; a byte with more results holds input as the queue drains.
// Reset (aresetn low, synchronous) returns the parse to the header ID phase
// and empties the result queue.
module dns_message_field_parser_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dnsp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dnsp_pkg::out_item_t m_data
);

    dnsp_pkg::result_set_t res;
    logic step;

    assign step = s_valid && s_ready;

    dnsp_core u_core (
        .aclk(aclk), .aresetn(aresetn), .step(step), .in_item(s_data), .res(res)
    );

    dnsp_out_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .res(res), .load(step), .can_load(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_data)
    );

endmodule
